FILE: hw/rtl/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the palette color mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

    // Payload field widths
    localparam int OP_W      = 3;
    localparam int VAL_W     = 16;
    localparam int FRAC_IN_W = 8;
    localparam int IDX_IN_W  = 8;
    localparam int COLOR_W   = 24;
    localparam int SIZE_W    = 9;
    localparam int IN_W      = 64;

    // Default configuration of the table
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_FRAC_BITS   = 8;

    // Remainder unit: dividend bits retired per cycle, steps per run
    localparam int DIV_STEP = 4;
    localparam int DIV_CYC  = VAL_W / DIV_STEP;

    // Register map (register index is paddr[2])
    localparam int  APB_AW   = 3;
    localparam logic REG_SIZE   = 1'b0;
    localparam logic REG_INTERP = 1'b1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_MAP     = 3'd0,
        OP_WRITE   = 3'd1,
        OP_ROT_FWD = 3'd2,
        OP_ROT_BWD = 3'd3,
        OP_INVERT  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RED_GO,
        S_RED,
        S_RD_LO,
        S_RD_HI,
        S_BLEND
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/pcm_ram.sv
// ----------------------------------------------------------------------------
// pcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pcm_divmod.sv
// ----------------------------------------------------------------------------
// pcm_divmod
// Iterative remainder unit: dividend mod divisor, DIV_STEP bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_divmod (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [pcm_pkg::VAL_W-1:0] i_dividend,
    input  wire logic [pcm_pkg::SIZE_W-1:0] i_divisor,
    output logic                           o_done,
    output logic      [pcm_pkg::SIZE_W-1:0] o_rem
);
    import pcm_pkg::*;

    localparam int CNT_W = $clog2(DIV_CYC);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIZE_W-1:0] r_rem;
    logic [VAL_W-1:0]  r_shift;
    logic [SIZE_W-1:0] n_rem;
    logic [SIZE_W:0]   trial;

    // Restoring remainder over the top DIV_STEP dividend bits
    always_comb begin
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {n_rem, r_shift[VAL_W-1-k]};
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = SIZE_W'(trial - {1'b0, i_divisor});
            end else begin
                n_rem = trial[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_CYC - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_shift <= i_dividend;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= r_shift << DIV_STEP;
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(DIV_CYC - 1)) && !i_start;
    assign o_rem  = n_rem;

endmodule

`default_nettype wire

FILE: hw/rtl/palette_color_mapper.sv
// ----------------------------------------------------------------------------
// palette_color_mapper
// Maps fixed-point iteration values to packed RGB through a rotatable,
// invertible palette with optional linear blending of neighbor entries.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel; opcode selects map, entry write,
//   rotate forward/backward or invert. Only a map item produces a transfer
//   on m_axis (one packed RGB word). Size and blend mode sit in two APB
//   registers at byte addresses 0 and 4.
//   Write, rotate and invert items take effect as soon as they are taken. A map
//   item runs through the iterative remainder unit for value mod size, then
//   two reads through the single read port of the palette RAM (floor,
//   ceiling) and one blend step into the output register; no further item
//   is taken until the map is done.
//   A write to the size register while idle or during an offset pass starts
//   a pass that recomputes the working offset (stored rotation offset modulo
//   the new size); s_axis_tready stays low meanwhile.
//   The output register holds a finished result while m_axis is stalled;
//   the next item is still taken, and a following map waits in its blend
//   step until the output register frees up.
//   Reset clears size to 256, blend mode, offset, invert flag and the
//   output valid flag. Palette entries are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_color_mapper #(
    parameter int MAX_ENTRIES = pcm_pkg::DEF_MAX_ENTRIES,
    parameter int FRAC_BITS   = pcm_pkg::DEF_FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // opcode[2:0], value_int[18:3], value_frac[26:19], entry_index[34:27],
    // entry_color[58:35], zero[63:59]
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [pcm_pkg::IN_W-1:0]    s_axis_tdata,
    // pixel_color[23:0]
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [pcm_pkg::COLOR_W-1:0] m_axis_tdata,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pcm_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import pcm_pkg::*;

    localparam int AW      = $clog2(MAX_ENTRIES);
    localparam int PW      = AW + 1;
    localparam int FB      = FRAC_BITS;
    localparam int WW      = FB + 1;
    localparam int FWX     = (FB > FRAC_IN_W) ? FB : FRAC_IN_W;
    localparam int SizeCap = (MAX_ENTRIES < 511) ? MAX_ENTRIES : 511;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SizeCap);
    localparam logic [WW-1:0]     ONE      = {1'b1, {FB{1'b0}}};

    // Input fields
    t_op                 in_op;
    logic [VAL_W-1:0]    in_int;
    logic [FRAC_IN_W-1:0] in_frac;
    logic [IDX_IN_W-1:0] in_idx;
    logic [COLOR_W-1:0]  in_color;
    logic [FWX-1:0]      frac_wide;
    logic [FB-1:0]       frac_in;

    assign in_op     = t_op'(s_axis_tdata[2:0]);
    assign in_int    = s_axis_tdata[18:3];
    assign in_frac   = s_axis_tdata[26:19];
    assign in_idx    = s_axis_tdata[34:27];
    assign in_color  = s_axis_tdata[58:35];
    assign frac_wide = FWX'(in_frac);
    assign frac_in   = frac_wide[FB-1:0];

    // Registers
    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_size;
    logic              r_interp;
    logic [AW-1:0]     r_offset;
    logic [AW-1:0]     r_off_red;   // r_offset modulo the size in force
    logic              r_invert;
    logic [AW-1:0]     r_lo;
    logic [FB-1:0]     r_frac;
    logic [COLOR_W-1:0] r_c_lo;
    logic              r_out_valid;
    logic [COLOR_W-1:0] r_out_data;

    // Configuration port
    logic cfg_wr;
    logic size_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign size_wr = cfg_wr && (paddr[2] == REG_SIZE);
    assign prdata  = (paddr[2] == REG_SIZE) ? 32'(r_size) : 32'(r_interp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_RESET;
            r_interp <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SIZE) begin
                r_size <= pwdata[SIZE_W-1:0];
            end else begin
                r_interp <= pwdata[0];
            end
        end
    end

    // Effective size
    logic [SIZE_W-1:0] n_eff;
    logic [PW-1:0]     n_pw;

    always_comb begin
        if (r_size == '0) begin
            n_eff = SIZE_W'(1);
        end else if (r_size > SIZE_CAP) begin
            n_eff = SIZE_CAP;
        end else begin
            n_eff = r_size;
        end
    end
    assign n_pw = PW'(n_eff);

    // Remainder unit, shared by map items and offset reduction
    logic              div_start;
    logic [VAL_W-1:0]  div_dividend;
    logic              div_done;
    logic [SIZE_W-1:0] div_rem;

    pcm_divmod u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (n_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Floor/ceiling to physical address
    logic [FB-1:0] f_eff;
    logic [PW-1:0] lo_pw, off_pw, hi_pw, lo_inc;
    logic [AW-1:0] phys_lo, phys_hi;

    function automatic logic [AW-1:0] to_phys(input logic [PW-1:0] x,
                                              input logic [PW-1:0] off,
                                              input logic [PW-1:0] n);
        logic [PW-1:0] p;
        if (x >= off) begin
            p = x - off;
        end else begin
            p = x + n - off;
        end
        return p[AW-1:0];
    endfunction

    assign f_eff   = r_interp ? r_frac : '0;
    assign lo_pw   = PW'(r_lo);
    assign off_pw  = PW'(r_off_red);
    assign lo_inc  = lo_pw + PW'(1);
    assign hi_pw   = (f_eff == '0) ? lo_pw : ((lo_inc == n_pw) ? '0 : lo_inc);
    assign phys_lo = to_phys(lo_pw, off_pw, n_pw);
    assign phys_hi = to_phys(hi_pw, off_pw, n_pw);

    // Palette memory; writes only happen while idle, read data is used only during a map
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [COLOR_W-1:0] ram_rdata;

    pcm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(in_idx)),
        .i_wdata (in_color),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = (r_state == S_RD_LO) ? phys_lo : phys_hi;

    // Blend, inversion applied to each entry first
    logic [COLOR_W-1:0] c_lo, c_hi, blended;
    logic [WW-1:0]      w_hi, w_lo;
    logic [WW+7:0]      prod_a [3];
    logic [WW+7:0]      prod_b [3];
    logic [WW+8:0]      sum_c  [3];

    assign c_lo = r_c_lo ^ {COLOR_W{r_invert}};
    assign c_hi = ram_rdata ^ {COLOR_W{r_invert}};
    assign w_hi = WW'(f_eff);
    assign w_lo = ONE - w_hi;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod_a[ch] = (WW+8)'(c_lo[8*ch +: 8]) * (WW+8)'(w_lo);
            prod_b[ch] = (WW+8)'(c_hi[8*ch +: 8]) * (WW+8)'(w_hi);
            sum_c[ch]  = (WW+9)'(prod_a[ch]) + (WW+9)'(prod_b[ch]);
            blended[8*ch +: 8] = sum_c[ch][FB+7:FB];
        end
    end

    // Control
    logic s_acc;
    logic idx_ok;
    logic out_free;
    logic out_load;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign idx_ok   = (32'(in_idx) < 32'(MAX_ENTRIES));
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_dividend  = in_int;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = !size_wr;
                if (size_wr) begin
                    n_state = S_RED_GO;
                end else if (s_axis_tvalid && (in_op == OP_MAP)) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
                ram_we = s_acc && (in_op == OP_WRITE) && idx_ok;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RD_LO;
                end
            end
            S_RED_GO: begin
                div_start    = 1'b1;
                div_dividend = VAL_W'(r_offset);
                n_state      = size_wr ? S_RED_GO : S_RED;
            end
            S_RED: begin
                if (size_wr) begin
                    n_state = S_RED_GO;
                end else if (div_done) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_LO: n_state = S_RD_HI;
            S_RD_HI: n_state = S_BLEND;
            S_BLEND: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Offset and invert flag; rotations step from the reduced offset
    logic [AW-1:0] rot_fwd, rot_bwd;

    assign rot_fwd = ((off_pw + PW'(1)) == n_pw) ? '0 : r_off_red + AW'(1);
    assign rot_bwd = (r_off_red == '0) ? AW'(n_pw - PW'(1)) : r_off_red - AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_off_red <= '0;
            r_invert  <= 1'b0;
        end else if ((r_state == S_RED) && div_done && !size_wr) begin
            r_off_red <= AW'(div_rem);
        end else if (s_acc) begin
            unique case (in_op)
                OP_WRITE: begin
                    if (idx_ok) begin
                        r_offset  <= '0;
                        r_off_red <= '0;
                        r_invert  <= 1'b0;
                    end
                end
                OP_ROT_FWD: begin
                    r_offset  <= rot_fwd;
                    r_off_red <= rot_fwd;
                end
                OP_ROT_BWD: begin
                    r_offset  <= rot_bwd;
                    r_off_red <= rot_bwd;
                end
                OP_INVERT: r_invert <= !r_invert;
                default: ;
            endcase
        end
    end

    // Map datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc && (in_op == OP_MAP)) begin
            r_frac <= frac_in;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_lo <= AW'(div_rem);
        end
        if (r_state == S_RD_HI) begin
            r_c_lo <= ram_rdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= blended;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks
    a_offset_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (off_pw < n_pw))
        else $error("rotation offset not below effective size");

    a_done_when_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV || r_state == S_RED))
        else $error("remainder unit finished outside a wait state");

    a_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_op == OP_WRITE) && idx_ok) |=> (r_offset == '0 && !r_invert))
        else $error("entry write did not clear offset and invert flag");

    a_blend_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEND && out_free) |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("blended result not presented");

endmodule

`default_nettype wire
